// ===== hw/rtl/rcwc_pkg.sv =====
// shared types and constants of the reno congestion window control unit
package rcwc_pkg;

  // window scale: one probe is one scale unit (power of two)
  localparam int unsigned WINDOW_SCALE = 1024;

  localparam int unsigned WIN_W   = 32;
  localparam int unsigned TIME_W  = 48;
  localparam int unsigned ACT_W   = 16;
  localparam int unsigned DEV_W   = 47;
  localparam int unsigned CFG_W   = 48;

  // divider sizes: quotient holds WINDOW_SCALE, divisor holds window / WINDOW_SCALE
  localparam int unsigned QW      = $clog2(WINDOW_SCALE + 1);
  localparam longint unsigned UNITS_MAX = 64'hFFFF_FFFF / WINDOW_SCALE;
  localparam int unsigned UNITS_W = $clog2(UNITS_MAX + 1);
  localparam int unsigned CNT_W   = $clog2(QW + 1);

  localparam logic [WIN_W-1:0]  SCALE_W      = WIN_W'(WINDOW_SCALE);
  localparam logic [WIN_W-1:0]  TWO_UNITS    = WIN_W'(2 * WINDOW_SCALE);
  localparam logic [WIN_W-1:0]  WIN_MAX      = {WIN_W{1'b1}};
  localparam logic [TIME_W-1:0] TIME_MAX     = {TIME_W{1'b1}};
  localparam logic [QW-1:0]     DIVIDEND     = QW'(WINDOW_SCALE);

  localparam logic [WIN_W-1:0]  RST_WINDOW    = 32'd2048;
  localparam logic [WIN_W-1:0]  RST_THRESHOLD = 32'd65536;
  localparam logic [TIME_W-1:0] RST_TIMEOUT   = 48'd100000000;

  typedef enum logic [1:0] {
    OP_RESPONSE = 2'd0,
    OP_DROP     = 2'd1,
    OP_LATE     = 2'd2,
    OP_RTT      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_INIT_WINDOW    = 2'd0,
    CFG_INIT_THRESHOLD = 2'd1,
    CFG_DEFAULT_TIMEOUT = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_COMMIT
  } rcwc_state_t;

endpackage

// ===== hw/rtl/rcwc_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module rcwc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rcwc_pkg::QW-1:0]      dividend,
  input  logic [rcwc_pkg::UNITS_W-1:0] divisor,
  output logic                       done,
  output logic [rcwc_pkg::QW-1:0]      quotient
);
  import rcwc_pkg::*;

  logic               busy;
  logic [CNT_W-1:0]   count;
  logic [UNITS_W-1:0] rem;
  logic [UNITS_W-1:0] dvsr;
  logic [QW-1:0]      num;
  logic [UNITS_W:0]   rem_shift;
  logic [UNITS_W-1:0] diff;
  logic               ge;
  logic [QW:0]        num_shift;

  assign rem_shift = {rem, num[QW-1]};
  // when ge holds the difference is below dvsr, so the low bits are exact
  assign diff      = rem_shift[UNITS_W-1:0] - dvsr;
  assign ge        = rem_shift >= {1'b0, dvsr};
  // dividend bits shift out the top while quotient bits shift in below
  assign num_shift = {num, ge};
  assign quotient  = num;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(QW);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      num  <= dividend;
      dvsr <= divisor;
    end else if (busy) begin
      rem <= ge ? diff : rem_shift[UNITS_W-1:0];
      num <= num_shift[QW-1:0];
    end
  end

endmodule

// ===== hw/rtl/reno_congestion_window_control_unit.sv =====
// top level: reno congestion window and timeout state with event sequencer
//
// usage:
//   input channel (in_valid / in_stall): one event per transaction with
//   operation, active_packets, rtt_smoothed, rtt_var.
//   output channel (out_valid / out_stall): one result per event with
//   window, threshold, timeout_ns, in_slow_start after that event.
//   config channel (cfg_valid / cfg_ready, always ready): index 0 initial
//   window, 1 initial threshold, 2 default timeout; a write also loads the
//   live window, threshold or timeout at once.
// event sequence:
//   drop, late response, rtt update and slow-start response: the event is
//   registered, then ST_COMMIT writes the result when the output is free.
//   congestion-avoidance response: in ST_DIVIDE the restoring divider forms
//   scale / units as a QW = clog2(WINDOW_SCALE+1) bit quotient (11 bits at
//   scale 1024), then ST_COMMIT writes the result.
//   in_stall stays high while an event is in work.
// reset: defaults loaded, saved pair cleared, no result pending.
// stall: a finished event waits until the output register is free.
module reno_congestion_window_control_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  operation,
  input  logic [rcwc_pkg::ACT_W-1:0]  active_packets,
  input  logic signed [rcwc_pkg::TIME_W-1:0] rtt_smoothed,
  input  logic [rcwc_pkg::DEV_W-1:0]  rtt_var,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rcwc_pkg::WIN_W-1:0]  window,
  output logic [rcwc_pkg::WIN_W-1:0]  threshold,
  output logic [rcwc_pkg::TIME_W-1:0] timeout_ns,
  output logic                        in_slow_start,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [rcwc_pkg::CFG_W-1:0]  cfg_data
);
  import rcwc_pkg::*;

  rcwc_state_t state, state_next;

  logic [WIN_W-1:0]  window_reg, threshold_reg, saved_window, saved_threshold;
  logic [TIME_W-1:0] timeout_reg, default_timeout;

  op_t                      op_q;
  logic [ACT_W-1:0]         active_q;
  logic signed [TIME_W-1:0] avg_q;
  logic [DEV_W-1:0]         dev_q;
  logic [QW-1:0]            quot_q;

  logic               accept, slow, div_start, div_done, commit;
  logic [QW-1:0]      div_quot;
  logic [WIN_W-1:0]   units_full;
  logic [UNITS_W-1:0] units;

  logic [WIN_W-1:0]  window_next, threshold_next;
  logic [TIME_W-1:0] timeout_next;
  logic [WIN_W:0]    grow_sum;
  logic [WIN_W:0]    drop_prod;
  logic [WIN_W-1:0]  drop_thr;
  logic signed [TIME_W:0] rtt_sum;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign slow      = window_reg < threshold_reg;

  assign units_full = window_reg / WINDOW_SCALE;
  assign units = (units_full == '0) ? UNITS_W'(1) : units_full[UNITS_W-1:0];

  rcwc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (DIVIDEND),
    .divisor  (units),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    div_start  = 1'b0;
    commit     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (op_t'(operation) == OP_RESPONSE && !slow) begin
            div_start  = 1'b1;
            state_next = ST_DIVIDE;
          end else begin
            state_next = ST_COMMIT;
          end
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (!out_valid || !out_stall) begin
          commit     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= op_t'(operation);
      active_q <= active_packets;
      avg_q    <= rtt_smoothed;
      dev_q    <= rtt_var;
    end
    if (div_done) begin
      quot_q <= div_quot;
    end
  end

  // grow by one unit in slow start, by the divider result in avoidance
  assign grow_sum  = {1'b0, window_reg} + (slow ? {1'b0, SCALE_W}
                                                : (WIN_W + 1)'(quot_q));
  assign drop_prod = (WIN_W + 1)'(active_q >> 1) * (WIN_W + 1)'(WINDOW_SCALE);
  assign drop_thr  = drop_prod[WIN_W] ? WIN_MAX : drop_prod[WIN_W-1:0];
  // arithmetic shift keeps the sign of a negative average
  assign rtt_sum   = (TIME_W + 1)'(avg_q >>> 3) + $signed({2'b00, dev_q});

  always_comb begin
    window_next    = window_reg;
    threshold_next = threshold_reg;
    timeout_next   = timeout_reg;
    case (op_q)
      OP_RESPONSE: begin
        window_next = grow_sum[WIN_W] ? WIN_MAX : grow_sum[WIN_W-1:0];
      end
      OP_DROP: begin
        window_next    = TWO_UNITS;
        threshold_next = (drop_thr < TWO_UNITS) ? TWO_UNITS : drop_thr;
      end
      OP_LATE: begin
        window_next    = (saved_window < TWO_UNITS) ? TWO_UNITS : saved_window;
        threshold_next = (saved_threshold < TWO_UNITS) ? TWO_UNITS : saved_threshold;
      end
      OP_RTT: begin
        if (avg_q == '1) begin
          timeout_next = default_timeout;
        end else if (rtt_sum[TIME_W]) begin
          timeout_next = '0;
        end else begin
          timeout_next = rtt_sum[TIME_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_reg      <= RST_WINDOW;
      threshold_reg   <= RST_THRESHOLD;
      saved_window    <= '0;
      saved_threshold <= '0;
      timeout_reg     <= RST_TIMEOUT;
      default_timeout <= RST_TIMEOUT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_INIT_WINDOW:    window_reg    <= cfg_data[WIN_W-1:0];
        CFG_INIT_THRESHOLD: threshold_reg <= cfg_data[WIN_W-1:0];
        CFG_DEFAULT_TIMEOUT: begin
          default_timeout <= cfg_data[TIME_W-1:0];
          timeout_reg     <= cfg_data[TIME_W-1:0];
        end
        default: ;
      endcase
    end else if (commit) begin
      window_reg    <= window_next;
      threshold_reg <= threshold_next;
      timeout_reg   <= timeout_next;
      if (op_q == OP_DROP) begin
        saved_window    <= window_reg;
        saved_threshold <= threshold_reg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      window        <= window_next;
      threshold     <= threshold_next;
      timeout_ns    <= timeout_next;
      in_slow_start <= window_next < threshold_next;
    end
  end

endmodule

// ===== tb/reno_congestion_window_control_unit_test.sv =====
// testbench of the reno congestion window control unit: directed and random events
`timescale 1ns / 100ps

module reno_congestion_window_control_unit_test;
  import rcwc_pkg::*;

  localparam logic [1:0]        CFG_UNUSED_INDEX = 2'd3;
  localparam logic [TIME_W-1:0] AVG_UNKNOWN      = {TIME_W{1'b1}};
  localparam int unsigned       SETTLE_CYCLES    = QW + 6;
  localparam int unsigned       PHASE_EVENTS     = 106;

  typedef struct packed {
    logic [WIN_W-1:0]  window;
    logic [WIN_W-1:0]  threshold;
    logic [TIME_W-1:0] timeout_ns;
    logic              in_slow_start;
  } cwnd_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          operation = OP_RESPONSE;
  logic [ACT_W-1:0]    active_packets = '0;
  logic [TIME_W-1:0]   rtt_smoothed = '0;
  logic [DEV_W-1:0]    rtt_var = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [WIN_W-1:0]    window;
  logic [WIN_W-1:0]    threshold;
  logic [TIME_W-1:0]   timeout_ns;
  logic                in_slow_start;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = CFG_INIT_WINDOW;
  logic [CFG_W-1:0]    cfg_data = '0;

  // predicted congestion state
  logic [WIN_W-1:0]  cwnd;
  logic [WIN_W-1:0]  ssthresh;
  logic [WIN_W-1:0]  saved_cwnd;
  logic [WIN_W-1:0]  saved_ssthresh;
  logic [TIME_W-1:0] rto_ns;
  logic [TIME_W-1:0] default_rto_ns;

  cwnd_result_t pending_results[$];
  int unsigned  error_count = 0;
  logic         steady = 1'b0;

  reno_congestion_window_control_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .active_packets (active_packets),
    .rtt_smoothed   (rtt_smoothed),
    .rtt_var        (rtt_var),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .window         (window),
    .threshold      (threshold),
    .timeout_ns     (timeout_ns),
    .in_slow_start  (in_slow_start),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    if (error_count < 100) $display("mismatch at %0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic logic [WIN_W-1:0] floor_two_units(logic [WIN_W-1:0] v);
    return (v < TWO_UNITS) ? TWO_UNITS : v;
  endfunction

  function automatic logic [WIN_W-1:0] sat_window(longint unsigned v);
    return (v > 64'hFFFF_FFFF) ? WIN_MAX : v[WIN_W-1:0];
  endfunction

  // applies one event to the predicted state and returns what the block should report
  function automatic cwnd_result_t reno_next_state(op_t op, logic [ACT_W-1:0] act,
                                                   logic [TIME_W-1:0] avg,
                                                   logic [DEV_W-1:0] dev);
    cwnd_result_t r;
    longint unsigned units;
    longint avg_shift;
    longint total;
    case (op)
      OP_RESPONSE: begin
        if (cwnd < ssthresh) begin
          cwnd = sat_window(longint'(cwnd) + WINDOW_SCALE);
        end else begin
          units = longint'(cwnd) / WINDOW_SCALE;
          if (units == 0) units = 1;
          cwnd = sat_window(longint'(cwnd) + WINDOW_SCALE / units);
        end
      end
      OP_DROP: begin
        saved_cwnd = cwnd;
        saved_ssthresh = ssthresh;
        ssthresh = floor_two_units(sat_window(longint'(act >> 1) * WINDOW_SCALE));
        cwnd = TWO_UNITS;
      end
      OP_LATE: begin
        cwnd = floor_two_units(saved_cwnd);
        ssthresh = floor_two_units(saved_ssthresh);
      end
      default: begin
        if (avg == AVG_UNKNOWN) begin
          rto_ns = default_rto_ns;
        end else begin
          // arithmetic shift, rounds toward minus infinity
          avg_shift = longint'($signed(avg)) >>> 3;
          total = avg_shift + longint'(dev);
          if (total < 0) rto_ns = '0;
          else if (total > longint'(TIME_MAX)) rto_ns = TIME_MAX;
          else rto_ns = total[TIME_W-1:0];
        end
      end
    endcase
    r.window = cwnd;
    r.threshold = ssthresh;
    r.timeout_ns = rto_ns;
    r.in_slow_start = (cwnd < ssthresh);
    return r;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_event(op_t op, logic [ACT_W-1:0] act, logic [TIME_W-1:0] avg,
                            logic [DEV_W-1:0] dev);
    while (!steady && $urandom_range(99) < 20) @(negedge clk);
    operation = op;
    active_packets = act;
    rtt_smoothed = avg;
    rtt_var = dev;
    in_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    pending_results.push_back(reno_next_state(op, act, avg, dev));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [CFG_W-1:0] data);
    wait_idle();
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    case (idx)
      CFG_INIT_WINDOW:     cwnd = data[WIN_W-1:0];
      CFG_INIT_THRESHOLD:  ssthresh = data[WIN_W-1:0];
      CFG_DEFAULT_TIMEOUT: begin
        default_rto_ns = data[TIME_W-1:0];
        rto_ns = data[TIME_W-1:0];
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // nothing outstanding yet: late response restores zeros floored to two units
  task automatic test_basic_events();
    send_event(OP_LATE, 16'd0, 48'd0, 47'd0);
    send_event(OP_RESPONSE, 16'd0, 48'd0, 47'd0);
    send_event(OP_RTT, 16'd0, AVG_UNKNOWN, 47'd12345);
    send_event(OP_DROP, 16'd0, 48'd0, 47'd0);
    send_event(OP_RESPONSE, 16'hFFFF, AVG_UNKNOWN, {DEV_W{1'b1}});
    send_event(OP_LATE, 16'd0, 48'd0, 47'd0);
    send_event(OP_DROP, 16'hFFFF, 48'd0, 47'd0);
    send_event(OP_DROP, 16'd1, 48'd0, 47'd0);
    send_event(OP_LATE, 16'd0, 48'd0, 47'd0);
    send_event(OP_RESPONSE, 16'd0, 48'd0, 47'd0);
  endtask

  task automatic test_rtt_corners();
    send_event(OP_RTT, 16'd0, 48'h7FFF_FFFF_FFFF, {DEV_W{1'b1}});
    send_event(OP_RTT, 16'd0, 48'h8000_0000_0000, 47'd0);
    send_event(OP_RTT, 16'd0, 48'hFFFF_FFFF_FFFE, 47'd0);
    send_event(OP_RTT, 16'd0, 48'hFFFF_FFFF_FFF7, 47'd5);
    send_event(OP_RTT, 16'd0, 48'd0, 47'd0);
    send_event(OP_RTT, 16'd0, AVG_UNKNOWN, 47'd0);
  endtask

  task automatic test_config_corners();
    // slow-start growth saturates
    write_register(CFG_INIT_WINDOW, 48'hFFFF_FFFF_FF00);
    write_register(CFG_INIT_THRESHOLD, 48'h0000_FFFF_FFFF);
    send_event(OP_RESPONSE, 16'd0, 48'd0, 47'd0);
    // avoidance with huge window adds nothing
    write_register(CFG_INIT_THRESHOLD, 48'd0);
    send_event(OP_RESPONSE, 16'd0, 48'd0, 47'd0);
    // window below one unit: divisor held at one
    write_register(CFG_INIT_WINDOW, 48'd100);
    send_event(OP_RESPONSE, 16'd0, 48'd0, 47'd0);
    write_register(CFG_DEFAULT_TIMEOUT, 48'd0);
    send_event(OP_RTT, 16'd0, AVG_UNKNOWN, 47'd9);
    write_register(CFG_DEFAULT_TIMEOUT, {CFG_W{1'b1}});
    write_register(CFG_UNUSED_INDEX, 48'h0123_4567_89AB);
    send_event(OP_RTT, 16'd0, AVG_UNKNOWN, 47'd0);
    write_register(CFG_INIT_WINDOW, 48'd0);
    write_register(CFG_INIT_THRESHOLD, 48'd0);
    send_event(OP_RESPONSE, 16'd0, 48'd0, 47'd0);
  endtask

  function automatic logic [WIN_W-1:0] pick_window_setting();
    case ($urandom_range(3))
      0:       return '0;
      1:       return WIN_MAX;
      2:       return $urandom;
      default: return $urandom_range(65536, 1024);
    endcase
  endfunction

  task automatic test_random_traffic(int unsigned phase);
    logic [TIME_W-1:0] avg;
    int unsigned pick;
    op_t op;
    if (phase != 0) begin
      write_register(CFG_INIT_WINDOW, CFG_W'({$urandom, $urandom}) & 48'hFFFF_0000_0000
                     | CFG_W'(pick_window_setting()));
      write_register(CFG_INIT_THRESHOLD, CFG_W'({$urandom, $urandom}) & 48'hFFFF_0000_0000
                     | CFG_W'(pick_window_setting()));
      case ($urandom_range(2))
        0:       write_register(CFG_DEFAULT_TIMEOUT, '0);
        1:       write_register(CFG_DEFAULT_TIMEOUT, {CFG_W{1'b1}});
        default: write_register(CFG_DEFAULT_TIMEOUT, CFG_W'({$urandom, $urandom}));
      endcase
    end
    steady = (phase == 2);
    for (int unsigned n = 0; n < PHASE_EVENTS; n++) begin
      // hold off until every result is back once per phase
      if (n == PHASE_EVENTS / 2) wait_idle();
      pick = $urandom_range(99);
      if (pick < 50) op = OP_RESPONSE;
      else if (pick < 70) op = OP_DROP;
      else if (pick < 85) op = OP_LATE;
      else op = OP_RTT;
      case ($urandom_range(9))
        0:       avg = AVG_UNKNOWN;
        1, 2:    avg = {1'b1, 47'({$urandom, $urandom})};
        3, 4, 5: avg = TIME_W'({$urandom, $urandom});
        default: avg = TIME_W'($urandom_range(32'h3FFF_FFFF));
      endcase
      send_event(op, 16'($urandom), avg, DEV_W'({$urandom, $urandom}));
    end
    steady = 1'b0;
  endtask

  // result transactions are checked against the oldest prediction
  always @(posedge clk) begin
    cwnd_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending");
      end else begin
        want = pending_results.pop_front();
        if (window !== want.window)
          report_mismatch($sformatf("window %0h, want %0h", window, want.window));
        if (threshold !== want.threshold)
          report_mismatch($sformatf("threshold %0h, want %0h", threshold, want.threshold));
        if (timeout_ns !== want.timeout_ns)
          report_mismatch($sformatf("timeout_ns %0h, want %0h", timeout_ns, want.timeout_ns));
        if (in_slow_start !== want.in_slow_start)
          report_mismatch($sformatf("in_slow_start %0b, want %0b", in_slow_start,
                                    want.in_slow_start));
      end
    end
  end

  always @(negedge clk) begin
    out_stall = !steady && ($urandom_range(99) < 20);
  end

  initial begin
    cwnd = RST_WINDOW;
    ssthresh = RST_THRESHOLD;
    saved_cwnd = '0;
    saved_ssthresh = '0;
    rto_ns = RST_TIMEOUT;
    default_rto_ns = RST_TIMEOUT;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_basic_events();
    test_rtt_corners();
    test_config_corners();
    for (int unsigned phase = 0; phase < 5; phase++) test_random_traffic(phase);
    wait_idle();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/rcwc_pkg.sv
hw/rtl/rcwc_div.sv
hw/rtl/reno_congestion_window_control_unit.sv
tb/reno_congestion_window_control_unit_test.sv
